### design/mfrs_pkg.sv
package mfrs_pkg;

	// Filter and field geometry.
	localparam int WINDOW      = 5;
	localparam int SAMPLE_BITS = 10;
	localparam int REG_W       = 11;
	localparam int VAL_W       = 12;

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int MEDIAN_RANK = WINDOW / 2;

	localparam int CMP_W    = (SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W;
	localparam int PROD_W   = SAMPLE_BITS + REG_W;
	localparam int DIV_W    = PROD_W + (PROD_W % 2);
	localparam int DIV_STEPS = DIV_W / 2;
	localparam int STEP_W   = $clog2(DIV_STEPS);

	localparam int VAL_MAX_I = 2 ** (VAL_W - 1) - 1;
	localparam int VAL_MIN_MAG = 2 ** (VAL_W - 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Configuration port.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_INPUT_LOW     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_INPUT_HIGH    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_OUTPUT_LOW    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OUTPUT_HIGH   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_INVERT_ENABLE = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DIGITAL_MODE  = 3'd5;

	localparam logic [REG_W-1:0] RST_INPUT_LOW   = 11'd0;
	localparam logic [REG_W-1:0] RST_INPUT_HIGH  = 11'd1024;
	localparam logic [REG_W-1:0] RST_OUTPUT_LOW  = 11'd0;
	localparam logic [REG_W-1:0] RST_OUTPUT_HIGH = 11'd127;

	typedef struct packed {
		logic [REG_W-1:0] input_low;
		logic [REG_W-1:0] input_high;
		logic [REG_W-1:0] output_low;
		logic [REG_W-1:0] output_high;
		logic             invert_enable;
		logic             digital_mode;
	} mfrs_cfg_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_RANK,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_DIV,
		B_FIX,
		B_OUT
	} back_state_t;

endpackage

### design/mfrs_if.sv
interface mfrs_in_if;
	import mfrs_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface mfrs_med_if;
	import mfrs_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] median;

	modport source (output valid, output median, input ready);
	modport sink (input valid, input median, output ready);
endinterface

interface mfrs_out_if;
	import mfrs_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [SAMPLE_BITS-1:0]   filtered;
	logic signed [VAL_W-1:0]  value;
	logic                     valid_res;

	modport source (output valid, output filtered, output value, output valid_res, input ready);
	modport sink (input valid, input filtered, input value, input valid_res, output ready);
endinterface

### design/median_filter_range_scaler.sv
// The front ranks one window entry per cycle and runs ahead through a two-entry queue;
// the back scales each median (multiply, two-bits-per-cycle divide, fix-up) and registers
// the result; digital mode, an out-of-range median or a zero input span skip the scaling.
// The back takes a new median only after the last result is loaded for output.
// Reset (arst_n, asynchronous, active low) clears the window to zero, the write slot,
// the queue and all handshakes, and loads the configuration registers with their defaults.
module median_filter_range_scaler
	import mfrs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	mfrs_in_if.sink               sample_ch,
	mfrs_out_if.source            result_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	mfrs_cfg_t cfg_q;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;

	mfrs_med_if front_med ();
	mfrs_med_if back_med ();

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_INPUT_LOW:     prdata = APB_DATA_W'(cfg_q.input_low);
			REG_INPUT_HIGH:    prdata = APB_DATA_W'(cfg_q.input_high);
			REG_OUTPUT_LOW:    prdata = APB_DATA_W'(cfg_q.output_low);
			REG_OUTPUT_HIGH:   prdata = APB_DATA_W'(cfg_q.output_high);
			REG_INVERT_ENABLE: prdata = APB_DATA_W'(cfg_q.invert_enable);
			REG_DIGITAL_MODE:  prdata = APB_DATA_W'(cfg_q.digital_mode);
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_low     <= RST_INPUT_LOW;
			cfg_q.input_high    <= RST_INPUT_HIGH;
			cfg_q.output_low    <= RST_OUTPUT_LOW;
			cfg_q.output_high   <= RST_OUTPUT_HIGH;
			cfg_q.invert_enable <= 1'b0;
			cfg_q.digital_mode  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_INPUT_LOW:     cfg_q.input_low     <= pwdata[REG_W-1:0];
				REG_INPUT_HIGH:    cfg_q.input_high    <= pwdata[REG_W-1:0];
				REG_OUTPUT_LOW:    cfg_q.output_low    <= pwdata[REG_W-1:0];
				REG_OUTPUT_HIGH:   cfg_q.output_high   <= pwdata[REG_W-1:0];
				REG_INVERT_ENABLE: cfg_q.invert_enable <= pwdata[0];
				REG_DIGITAL_MODE:  cfg_q.digital_mode  <= pwdata[0];
				default: ;
			endcase
		end
	end

	mfrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.med_ch    (front_med)
	);

	mfrs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_ch  (front_med),
		.rd_ch  (back_med)
	);

	mfrs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.med_ch    (back_med),
		.result_ch (result_ch)
	);

endmodule

### design/mfrs_front.sv
module mfrs_front
	import mfrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	mfrs_in_if.sink           sample_ch,
	mfrs_med_if.source        med_ch
);

	front_state_t state_q, state_d;

	logic [SAMPLE_BITS-1:0] window_q [WINDOW];
	logic [SLOT_W-1:0]      slot_q;
	logic [SLOT_W-1:0]      cand_q;
	logic [SAMPLE_BITS-1:0] median_q;

	logic [SAMPLE_BITS-1:0] cand;
	logic [CNT_W-1:0]       less_cnt;
	logic [CNT_W-1:0]       leq_cnt;
	logic                   hit;
	logic                   last_cand;
	logic                   take;

	// One candidate per cycle: its rank is counted against every window entry.
	always_comb begin
		cand     = window_q[cand_q];
		less_cnt = '0;
		leq_cnt  = '0;
		for (int j = 0; j < WINDOW; j++) begin
			less_cnt = less_cnt + CNT_W'(window_q[j] < cand);
			leq_cnt  = leq_cnt + CNT_W'(window_q[j] <= cand);
		end
		hit = (less_cnt <= CNT_W'(MEDIAN_RANK)) && (CNT_W'(MEDIAN_RANK) < leq_cnt);
		last_cand = (cand_q == SLOT_W'(WINDOW - 1));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (sample_ch.valid) state_d = F_RANK;
			end
			F_RANK: begin
				if (hit || last_cand) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (med_ch.ready) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		sample_ch.ready = (state_q == F_IDLE);
		med_ch.valid    = (state_q == F_PUSH);
		med_ch.median   = median_q;
		take            = sample_ch.valid && sample_ch.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			slot_q  <= '0;
			cand_q  <= '0;
			for (int i = 0; i < WINDOW; i++) window_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (take) begin
				window_q[slot_q] <= sample_ch.sample;
				slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : SLOT_W'(slot_q + 1'b1);
				cand_q <= '0;
			end else if (state_q == F_RANK) begin
				cand_q <= SLOT_W'(cand_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_RANK && (hit || last_cand)) median_q <= cand;
	end

endmodule

### design/mfrs_queue.sv
module mfrs_queue
	import mfrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	mfrs_med_if.sink   wr_ch,
	mfrs_med_if.source rd_ch
);

	logic [SAMPLE_BITS-1:0] data_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]      wr_ptr_q;
	logic [QPTR_W-1:0]      rd_ptr_q;
	logic [QCNT_W-1:0]      count_q;
	logic                   push;
	logic                   pop;

	always_comb begin
		wr_ch.ready  = (count_q != QCNT_W'(QUEUE_DEPTH));
		rd_ch.valid  = (count_q != '0);
		rd_ch.median = data_q[rd_ptr_q];
		push         = wr_ch.valid && wr_ch.ready;
		pop          = rd_ch.valid && rd_ch.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			if (pop) rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			if (push && !pop) count_q <= QCNT_W'(count_q + 1'b1);
			else if (pop && !push) count_q <= QCNT_W'(count_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) data_q[wr_ptr_q] <= wr_ch.median;
	end

endmodule

### design/mfrs_back.sv
module mfrs_back
	import mfrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  mfrs_cfg_t   cfg,
	mfrs_med_if.sink    med_ch,
	mfrs_out_if.source  result_ch
);

	back_state_t state_q, state_d;

	logic [SAMPLE_BITS-1:0]  med_q;
	logic [SAMPLE_BITS-1:0]  diff_q;
	logic [REG_W-1:0]        mag_q;
	logic                    neg_q;
	logic [REG_W-1:0]        den_q;
	logic [DIV_W-1:0]        dq_q;
	logic [REG_W-1:0]        rem_q;
	logic [STEP_W-1:0]       step_q;
	logic signed [VAL_W-1:0] res_q;
	logic                    vres_q;
	logic                    scaled_q;

	logic                    out_valid_q;
	logic [SAMPLE_BITS-1:0]  out_filt_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic                    out_vres_q;

	logic                    pop;
	logic                    in_range;
	logic                    span_zero;
	logic [CMP_W-1:0]        med_ext;
	logic signed [REG_W:0]   out_span;
	logic [DIV_W-1:0]        dq_next;
	logic [REG_W-1:0]        rem_next;
	logic [REG_W:0]          rem_try;
	logic [DIV_W:0]          neg_mag;
	logic signed [VAL_W-1:0] fix_val;
	logic signed [VAL_W:0]   inv_diff;
	logic [VAL_W:0]          inv_abs;
	logic signed [VAL_W-1:0] final_val;
	logic                    last_step;
	logic                    load_out;

	always_comb begin
		med_ext   = CMP_W'(med_ch.median);
		in_range  = (med_ext >= CMP_W'(cfg.input_low)) && (med_ext <= CMP_W'(cfg.input_high));
		span_zero = (cfg.input_high == cfg.input_low);
		out_span  = $signed({1'b0, cfg.output_high}) - $signed({1'b0, cfg.output_low});
		last_step = (step_q == STEP_W'(DIV_STEPS - 1));
	end

	// Restoring divider, two quotient bits per cycle.
	always_comb begin
		dq_next  = dq_q;
		rem_next = rem_q;
		rem_try  = '0;
		for (int k = 0; k < 2; k++) begin
			rem_try = {rem_next, dq_next[DIV_W-1]};
			dq_next = {dq_next[DIV_W-2:0], 1'b0};
			if (rem_try >= {1'b0, den_q}) begin
				rem_try    = rem_try - {1'b0, den_q};
				dq_next[0] = 1'b1;
			end
			rem_next = rem_try[REG_W-1:0];
		end
	end

	// Floor of the signed quotient, clamped to the result range.
	always_comb begin
		neg_mag = {1'b0, dq_q} + (DIV_W + 1)'(rem_q != '0);
		if (neg_q) begin
			if (neg_mag > (DIV_W + 1)'(VAL_MIN_MAG)) fix_val = VAL_W'(-VAL_MIN_MAG);
			else fix_val = VAL_W'(-$signed(neg_mag));
		end else begin
			if (dq_q > DIV_W'(VAL_MAX_I)) fix_val = VAL_W'(VAL_MAX_I);
			else fix_val = $signed(dq_q[VAL_W-1:0]);
		end
	end

	always_comb begin
		inv_diff = $signed({res_q[VAL_W-1], res_q}) - $signed({2'b00, cfg.output_high});
		inv_abs  = inv_diff[VAL_W] ? (VAL_W + 1)'(-inv_diff) : inv_diff;
		if (scaled_q && cfg.invert_enable) begin
			if (inv_abs > (VAL_W + 1)'(VAL_MAX_I)) final_val = VAL_W'(VAL_MAX_I);
			else final_val = $signed(inv_abs[VAL_W-1:0]);
		end else begin
			final_val = res_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (med_ch.valid) begin
					if (!cfg.digital_mode && in_range && !span_zero) state_d = B_MUL;
					else state_d = B_OUT;
				end
			end
			B_MUL: state_d = B_DIV;
			B_DIV: begin
				if (last_step) state_d = B_FIX;
			end
			B_FIX: state_d = B_OUT;
			B_OUT: begin
				if (!out_valid_q || result_ch.ready) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		med_ch.ready        = (state_q == B_IDLE);
		pop                 = med_ch.valid && med_ch.ready;
		load_out            = (state_q == B_OUT) && (!out_valid_q || result_ch.ready);
		result_ch.valid     = out_valid_q;
		result_ch.filtered  = out_filt_q;
		result_ch.value     = out_value_q;
		result_ch.valid_res = out_vres_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_MUL) step_q <= '0;
			else if (state_q == B_DIV) step_q <= STEP_W'(step_q + 1'b1);
			if (load_out) out_valid_q <= 1'b1;
			else if (result_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			med_q    <= med_ch.median;
			diff_q   <= SAMPLE_BITS'(med_ext - CMP_W'(cfg.input_low));
			mag_q    <= out_span[REG_W] ? REG_W'(-out_span) : out_span[REG_W-1:0];
			neg_q    <= out_span[REG_W];
			den_q    <= REG_W'(cfg.input_high - cfg.input_low);
			scaled_q <= 1'b0;
			if (cfg.digital_mode) begin
				res_q  <= (med_ch.median != '0) ? VAL_W'(1) : VAL_W'(-1);
				vres_q <= 1'b1;
			end else begin
				res_q  <= VAL_W'(-1);
				vres_q <= 1'b0;
			end
		end
		if (state_q == B_MUL) begin
			dq_q  <= DIV_W'(diff_q * mag_q);
			rem_q <= '0;
		end
		if (state_q == B_DIV) begin
			dq_q  <= dq_next;
			rem_q <= rem_next;
		end
		if (state_q == B_FIX) begin
			res_q    <= fix_val;
			vres_q   <= 1'b1;
			scaled_q <= 1'b1;
		end
		if (load_out) begin
			out_filt_q  <= med_q;
			out_value_q <= final_val;
			out_vres_q  <= vres_q;
		end
	end

endmodule

### tb/median_filter_range_scaler_tb.sv
`timescale 1ns / 1ps

module median_filter_range_scaler_tb;
	import mfrs_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0]  filtered;
		logic signed [VAL_W-1:0] value;
		logic                    valid_res;
	} reading_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	mfrs_in_if  sample_if ();
	mfrs_out_if result_if ();

	median_filter_range_scaler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_if),
		.result_ch (result_if),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Shadow of the block: configuration, sample window and next write slot.
	mfrs_cfg_t              scale_cfg;
	logic [SAMPLE_BITS-1:0] sample_window [WINDOW];
	int unsigned            fill_slot;

	reading_t pending_readings [$];
	reading_t head_reading;
	int       error_count;
	int       send_idle_pct;
	int       recv_idle_pct;
	int       stall_request;
	int       stall_left;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#4ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic log_error(input string msg);
		error_count++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	function automatic longint clamp_value(input longint v);
		if (v > VAL_MAX_I)
			return VAL_MAX_I;
		if (v < -VAL_MIN_MAG)
			return -VAL_MIN_MAG;
		return v;
	endfunction

	// Writes one sample into the window and works out the reading the block must give.
	function automatic reading_t filter_and_scale(input logic [SAMPLE_BITS-1:0] s);
		reading_t               r;
		logic [SAMPLE_BITS-1:0] med;
		int                     less;
		int                     leq;
		longint                 in_span;
		longint                 out_span;
		longint                 num;
		longint                 q;
		sample_window[fill_slot] = s;
		fill_slot = (fill_slot == WINDOW - 1) ? 0 : fill_slot + 1;

		// Every entry whose rank range covers the middle position has the same value.
		med = '0;
		for (int i = 0; i < WINDOW; i++) begin
			less = 0;
			leq = 0;
			for (int j = 0; j < WINDOW; j++) begin
				if (sample_window[j] < sample_window[i])
					less++;
				if (sample_window[j] <= sample_window[i])
					leq++;
			end
			if (less <= MEDIAN_RANK && MEDIAN_RANK < leq)
				med = sample_window[i];
		end

		r.filtered = med;
		r.value = VAL_W'(-1);
		r.valid_res = 1'b0;
		if (scale_cfg.digital_mode) begin
			r.value = (med != 0) ? VAL_W'(1) : VAL_W'(-1);
			r.valid_res = 1'b1;
		end else if (med >= scale_cfg.input_low && med <= scale_cfg.input_high) begin
			in_span = longint'(scale_cfg.input_high) - longint'(scale_cfg.input_low);
			if (in_span != 0) begin
				out_span = longint'(scale_cfg.output_high) - longint'(scale_cfg.output_low);
				num = (longint'(med) - longint'(scale_cfg.input_low)) * out_span;
				q = num / in_span;
				// A reversed output span gives a negative numerator; round toward minus infinity.
				if ((num % in_span) != 0 && num < 0)
					q = q - 1;
				q = clamp_value(q);
				if (scale_cfg.invert_enable) begin
					q = q - longint'(scale_cfg.output_high);
					if (q < 0)
						q = -q;
					q = clamp_value(q);
				end
				r.value = q[VAL_W-1:0];
				r.valid_res = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [APB_DATA_W-1:0] reg_view(input logic [REG_IDX_W-1:0] idx);
		logic [APB_DATA_W-1:0] r;
		r = '0;
		case (idx)
			REG_INPUT_LOW:     r[REG_W-1:0] = scale_cfg.input_low;
			REG_INPUT_HIGH:    r[REG_W-1:0] = scale_cfg.input_high;
			REG_OUTPUT_LOW:    r[REG_W-1:0] = scale_cfg.output_low;
			REG_OUTPUT_HIGH:   r[REG_W-1:0] = scale_cfg.output_high;
			REG_INVERT_ENABLE: r[0] = scale_cfg.invert_enable;
			REG_DIGITAL_MODE:  r[0] = scale_cfg.digital_mode;
			default: ;
		endcase
		return r;
	endfunction

	// Starts and ends at a falling edge and leaves the bus idle after the access phase.
	task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
			input logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Upper data bits carry noise; the block keeps only the register's own width.
	task automatic set_register(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] v);
		logic [APB_DATA_W-1:0] wdata;
		logic [APB_DATA_W-1:0] rdata;
		wdata = $urandom();
		case (idx)
			REG_INPUT_LOW:     scale_cfg.input_low = v;
			REG_INPUT_HIGH:    scale_cfg.input_high = v;
			REG_OUTPUT_LOW:    scale_cfg.output_low = v;
			REG_OUTPUT_HIGH:   scale_cfg.output_high = v;
			REG_INVERT_ENABLE: scale_cfg.invert_enable = v[0];
			REG_DIGITAL_MODE:  scale_cfg.digital_mode = v[0];
			default: ;
		endcase
		if (idx == REG_INVERT_ENABLE || idx == REG_DIGITAL_MODE)
			wdata[0] = v[0];
		else
			wdata[REG_W-1:0] = v;
		apb_access(1'b1, idx, wdata, rdata);
		apb_access(1'b0, idx, '0, rdata);
		if (rdata !== reg_view(idx))
			log_error($sformatf("register %0d reads %0h, want %0h", idx, rdata, reg_view(idx)));
	endtask

	// Leaves valid high at the falling edge after the transaction; the next call or
	// wait_for_idle decides what it does next.
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_if.valid <= 1'b0;
			@(negedge clk);
		end
		sample_if.valid <= 1'b1;
		sample_if.sample <= s;
		@(posedge clk);
		while (!sample_if.ready)
			@(posedge clk);
		@(negedge clk);
		pending_readings.insert(pending_readings.size(), filter_and_scale(s));
	endtask

	task automatic send_run(input logic [SAMPLE_BITS-1:0] s, input int n);
		repeat (n)
			send_sample(s);
	endtask

	task automatic wait_for_idle();
		sample_if.valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	function automatic logic [REG_W-1:0] pick_level();
		case ($urandom_range(5))
			0: return '0;
			1: return 11'd1024;
			2: return 11'd1023;
			default: return REG_W'($urandom_range(1024, 0));
		endcase
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		int unsigned top;
		top = (scale_cfg.input_high > 1023) ? 1023 : scale_cfg.input_high;
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2, 3: begin
				if (scale_cfg.input_low <= top)
					return SAMPLE_BITS'($urandom_range(top, scale_cfg.input_low));
			end
			default: ;
		endcase
		return SAMPLE_BITS'($urandom());
	endfunction

	task automatic pick_random_setting();
		logic [REG_W-1:0] lo;
		logic [REG_W-1:0] hi;
		// Mostly an ordinary input range, sometimes arbitrary ends including reversed ones.
		if ($urandom_range(3) != 0) begin
			lo = REG_W'($urandom_range(700, 0));
			hi = REG_W'($urandom_range(1024, lo));
		end else begin
			lo = pick_level();
			hi = pick_level();
		end
		set_register(REG_INPUT_LOW, lo);
		set_register(REG_INPUT_HIGH, hi);
		set_register(REG_OUTPUT_LOW, pick_level());
		set_register(REG_OUTPUT_HIGH, pick_level());
		set_register(REG_INVERT_ENABLE, REG_W'($urandom_range(1)));
		set_register(REG_DIGITAL_MODE, REG_W'($urandom_range(5) == 0));
	endtask

	task automatic test_register_defaults();
		logic [APB_DATA_W-1:0] rdata;
		for (int i = REG_INPUT_LOW; i <= REG_DIGITAL_MODE; i++) begin
			apb_access(1'b0, REG_IDX_W'(i), '0, rdata);
			if (rdata !== reg_view(REG_IDX_W'(i)))
				log_error($sformatf("reset value of register %0d is %0h, want %0h",
					i, rdata, reg_view(REG_IDX_W'(i))));
		end
	endtask

	task automatic test_directed_cases();
		logic [APB_DATA_W-1:0] rdata;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// Default scaling; the cleared window holds the median at zero for two samples.
		send_run(10'd1023, 3);
		wait_for_idle();

		// Below the input range, inside it with inversion, then above it.
		set_register(REG_INPUT_LOW, 11'd100);
		set_register(REG_INPUT_HIGH, 11'd200);
		set_register(REG_OUTPUT_HIGH, 11'd1024);
		set_register(REG_INVERT_ENABLE, 11'd1);
		send_run(10'd50, 3);
		send_run(10'd150, 3);
		send_run(10'd300, 3);
		wait_for_idle();

		// Zero input span with the reading sitting exactly on it.
		set_register(REG_INPUT_LOW, 11'd300);
		set_register(REG_INPUT_HIGH, 11'd300);
		send_run(10'd300, 2);
		wait_for_idle();

		// Zero output span: the quotient is zero, inverted against output_high, and still counts as a reading.
		set_register(REG_INPUT_LOW, 11'd0);
		set_register(REG_INPUT_HIGH, 11'd1024);
		set_register(REG_OUTPUT_LOW, 11'd500);
		set_register(REG_OUTPUT_HIGH, 11'd500);
		send_run(10'd700, 3);
		wait_for_idle();

		// Reversed output span; the negative quotient must round down.
		set_register(REG_INPUT_HIGH, 11'd1023);
		set_register(REG_OUTPUT_LOW, 11'd1024);
		set_register(REG_OUTPUT_HIGH, 11'd0);
		set_register(REG_INVERT_ENABLE, 11'd0);
		send_run(10'd1, 3);
		wait_for_idle();

		// Writes to unmapped addresses must leave every register alone.
		apb_access(1'b1, REG_SPARE_LO, $urandom(), rdata);
		apb_access(1'b1, REG_SPARE_HI, $urandom(), rdata);
		for (int i = REG_INPUT_LOW; i <= REG_DIGITAL_MODE; i++) begin
			apb_access(1'b0, REG_IDX_W'(i), '0, rdata);
			if (rdata !== reg_view(REG_IDX_W'(i)))
				log_error($sformatf("register %0d changed to %0h by an unmapped write", i, rdata));
		end

		// On/off mode: a nonzero median first, then a zero one.
		set_register(REG_DIGITAL_MODE, 11'd1);
		send_run(10'd0, 3);
		wait_for_idle();
	endtask

	task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		repeat (3) begin
			pick_random_setting();
			repeat (52)
				send_sample(pick_sample());
			wait_for_idle();
		end
	endtask

	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		pick_random_setting();
		// The output stays blocked long enough for the pipeline to fill and stop taking samples.
		stall_request = 300;
		repeat (24)
			send_sample(pick_sample());
		wait_for_idle();
		repeat (8)
			send_sample(pick_sample());
		wait_for_idle();
	endtask

	always @(negedge clk) begin
		if (stall_request != 0) begin
			stall_left = stall_request;
			stall_request = 0;
		end
		if (stall_left != 0) begin
			stall_left--;
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_readings.size() == 0) begin
				log_error($sformatf("unexpected transaction: filtered %0d value %0d",
					result_if.filtered, result_if.value));
			end else begin
				head_reading = pending_readings.pop_front();
				if (result_if.filtered !== head_reading.filtered)
					log_error($sformatf("filtered %0d, want %0d",
						result_if.filtered, head_reading.filtered));
				if (result_if.value !== head_reading.value)
					log_error($sformatf("value %0d, want %0d (filtered %0d)",
						result_if.value, head_reading.value, head_reading.filtered));
				if (result_if.valid_res !== head_reading.valid_res)
					log_error($sformatf("valid_res %0b, want %0b (filtered %0d)",
						result_if.valid_res, head_reading.valid_res, head_reading.filtered));
			end
		end
	end

	initial begin
		error_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = 0;
		stall_left = 0;
		scale_cfg = '{input_low: RST_INPUT_LOW, input_high: RST_INPUT_HIGH,
			output_low: RST_OUTPUT_LOW, output_high: RST_OUTPUT_HIGH,
			invert_enable: 1'b0, digital_mode: 1'b0};
		for (int i = 0; i < WINDOW; i++)
			sample_window[i] = '0;
		fill_slot = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_if.valid = 1'b0;
		sample_if.sample = '0;
		result_if.ready = 1'b0;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_register_defaults();
		test_directed_cases();
		test_random_traffic(22, 59);
		test_random_traffic(59, 22);
		test_random_traffic(0, 0);
		test_output_backpressure();

		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### sim.f
design/mfrs_pkg.sv
design/mfrs_if.sv
design/mfrs_front.sv
design/mfrs_queue.sv
design/mfrs_back.sv
design/median_filter_range_scaler.sv
tb/median_filter_range_scaler_tb.sv
